>>> rtl/core/tcs_pkg.sv
package tcs_pkg;

    localparam logic [15:0] ADDR_FIRST    = 16'd12;
    localparam logic [15:0] ADDR_LAST     = 16'd19;
    localparam logic [15:0] SEG_FIRST     = 16'd20;
    localparam logic [15:0] IDX_MAX       = 16'hFFFF;
    localparam logic [15:0] IDX_IHL       = 16'd0;
    localparam logic [15:0] IDX_LEN_HI    = 16'd2;
    localparam logic [15:0] IDX_LEN_LO    = 16'd3;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [14:0] CSUM_WORD_OFF = 15'd8;
    localparam logic [16:0] PROTO_TCP     = 17'd6;

    typedef struct packed {
        logic [15:0] word;
        logic [16:0] tail;
        logic        last;
        logic        bad;
        logic        err;
    } item_t;

endpackage

>>> rtl/core/tcs_front.sv
module tcs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    input  logic [7:0]    pkt_byte,
    input  logic          frame_last,
    input  logic          full,
    output logic          push,
    output tcs_pkg::item_t item
);

    logic [15:0] idx_reg, idx_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] tot_reg, tot_next;
    logic [7:0]  hold_reg, hold_next;
    logic        open_reg, open_next;

    logic [15:0] hdr_cur;
    logic [15:0] hdr_eff;
    logic        seg_hit;
    logic        csum_pos;
    logic [7:0]  b_eff;
    logic [15:0] word;
    logic        len_ok;
    logic        short_frame;
    logic [15:0] seg_len;
    logic [16:0] pad;

    assign push = pkt_valid && !full;

    always_comb
    begin
        hw_next  = hw_reg;
        tot_next = tot_reg;
        if (idx_reg == tcs_pkg::IDX_IHL)
        begin
            hw_next = pkt_byte[3:0];
        end
        else if (idx_reg == tcs_pkg::IDX_LEN_HI)
        begin
            tot_next = {pkt_byte, tot_reg[7:0]};
        end
        else if (idx_reg == tcs_pkg::IDX_LEN_LO)
        begin
            tot_next = {tot_reg[15:8], pkt_byte};
        end
    end

    assign hdr_cur  = {10'd0, hw_reg, 2'b00};
    assign seg_hit  = (idx_reg >= tcs_pkg::SEG_FIRST) && (idx_reg >= hdr_cur)
                      && (idx_reg < tot_reg);
    assign csum_pos = idx_reg[15:1] == ({10'd0, hw_reg, 1'b0} + tcs_pkg::CSUM_WORD_OFF);
    assign b_eff    = csum_pos ? 8'd0 : pkt_byte;

    always_comb
    begin
        word      = 16'd0;
        hold_next = hold_reg;
        open_next = open_reg;
        if ((idx_reg >= tcs_pkg::ADDR_FIRST) && (idx_reg <= tcs_pkg::ADDR_LAST))
        begin
            word = idx_reg[0] ? {8'd0, pkt_byte} : {pkt_byte, 8'd0};
        end
        else if (seg_hit)
        begin
            if (idx_reg[0])
            begin
                word      = {hold_reg, b_eff};
                open_next = 1'b0;
            end
            else
            begin
                hold_next = b_eff;
                open_next = 1'b1;
            end
        end
    end

    assign hdr_eff     = {10'd0, hw_next, 2'b00};
    assign len_ok      = (hw_next >= tcs_pkg::IHL_MIN) && (tot_next >= hdr_eff);
    assign short_frame = ({1'b0, idx_reg} + 17'd1) < {1'b0, tot_next};
    assign seg_len     = tot_next - hdr_eff;
    assign pad         = open_next ? {1'b0, hold_next, 8'd0} : 17'd0;

    always_comb
    begin
        item.word = word;
        item.last = frame_last;
        item.bad  = 1'b0;
        item.err  = 1'b0;
        item.tail = 17'd0;
        if (frame_last)
        begin
            if (len_ok)
            begin
                item.tail = {1'b0, seg_len} + pad + tcs_pkg::PROTO_TCP;
                item.err  = short_frame;
            end
            else
            begin
                item.bad = 1'b1;
                item.err = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 16'd0;
            hw_reg   <= 4'd0;
            tot_reg  <= 16'd0;
            hold_reg <= 8'd0;
            open_reg <= 1'b0;
        end
        else if (push)
        begin
            if (frame_last)
            begin
                idx_reg  <= 16'd0;
                hw_reg   <= 4'd0;
                tot_reg  <= 16'd0;
                hold_reg <= 8'd0;
                open_reg <= 1'b0;
            end
            else
            begin
                idx_reg  <= idx_next;
                hw_reg   <= hw_next;
                tot_reg  <= tot_next;
                hold_reg <= hold_next;
                open_reg <= open_next;
            end
        end
    end

    assign idx_next = (idx_reg == tcs_pkg::IDX_MAX) ? idx_reg : idx_reg + 16'd1;

endmodule

>>> rtl/core/tcs_fifo.sv
module tcs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcs_pkg::item_t wr_item,
    input  logic           pop,
    output logic           full,
    output logic           nonempty,
    output tcs_pkg::item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcs_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign nonempty = count_reg != '0;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue read while empty");
`endif

endmodule

>>> rtl/core/tcs_back.sv
module tcs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           nonempty,
    input  tcs_pkg::item_t item,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_stall,
    output logic [15:0]    tcp_checksum,
    output logic           length_error
);

    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic        fin_valid_reg;
    logic [31:0] fin_sum_reg;
    logic        fin_bad_reg;
    logic        fin_err_reg;
    logic        out_valid_reg;
    logic [15:0] csum_reg;
    logic        err_reg;
    logic        out_free;
    logic        fin_free;
    logic        fin_move;
    logic [16:0] fold1;
    logic [16:0] fold2;

    assign out_free = !out_valid_reg || !res_stall;
    assign fin_move = fin_valid_reg && out_free;
    assign fin_free = !fin_valid_reg || out_free;
    assign pop      = nonempty && (!item.last || fin_free);
    assign sum_next = sum_reg + 32'(item.word) + 32'(item.tail);

    assign fold1 = {1'b0, fin_sum_reg[31:16]} + {1'b0, fin_sum_reg[15:0]};
    assign fold2 = fold1 + 17'(fold1[16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= 32'd0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                sum_reg <= item.last ? 32'd0 : sum_next;
            end
            if (pop && item.last)
            begin
                fin_valid_reg <= 1'b1;
            end
            else if (fin_move)
            begin
                fin_valid_reg <= 1'b0;
            end
            if (fin_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            fin_sum_reg <= sum_next;
            fin_bad_reg <= item.bad;
            fin_err_reg <= item.err;
        end
        if (fin_move)
        begin
            csum_reg <= fin_bad_reg ? 16'd0 : ~fold2[15:0];
            err_reg  <= fin_err_reg;
        end
    end

    assign res_valid    = out_valid_reg;
    assign tcp_checksum = csum_reg;
    assign length_error = err_reg;

`ifndef SYNTH
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && item.last) |=> sum_reg == 32'd0)
        else $error("running sum not cleared after frame end");

    a_fin_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !out_free) |=> fin_valid_reg)
        else $error("finished sum dropped while output stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_move && fin_bad_reg) |=> (tcp_checksum == 16'd0) && length_error)
        else $error("invalid lengths not reported as zero with error");
`endif

endmodule

>>> rtl/core/tcp_checksum_ipv4_stream.sv
// TCP checksum of an IPv4 packet streamed in one byte per request.
// Input channel: pkt_valid / pkt_stall carry pkt_byte and frame_last;
// frame_last marks the final byte of a frame.
// Output channel: res_valid / res_stall carry tcp_checksum and length_error;
// one result request per frame, issued for the frame_last byte.
// Throughput: one byte per cycle while pkt_stall is low. The front end tracks the byte
// position and builds one 16-bit word per byte, the back end adds it into a
// 32-bit accumulator, a third register folds and inverts the final sum.
// The final sum is held in a finish register, then folded into the output register.
// A queue of FIFO_DEPTH entries sits between front and back end; while
// res_stall is high the back end holds up to two finished frames, bytes
// keep flowing until a third frame end reaches the head of the queue,
// after which the queue fills and pkt_stall rises.
// Reset (rst_n low, asynchronous) drops any partial frame and any pending
// result; the first byte after reset is byte 0 of a new frame.
module tcp_checksum_ipv4_stream #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_stall,
    input  logic [7:0]  pkt_byte,
    input  logic        frame_last,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] tcp_checksum,
    output logic        length_error
);

    tcs_pkg::item_t wr_item;
    tcs_pkg::item_t rd_item;
    logic           push;
    logic           pop;
    logic           full;
    logic           nonempty;

    assign pkt_stall = full;

    tcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_byte   (pkt_byte),
        .frame_last (frame_last),
        .full       (full),
        .push       (push),
        .item       (wr_item)
    );

    tcs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (wr_item),
        .pop      (pop),
        .full     (full),
        .nonempty (nonempty),
        .rd_item  (rd_item)
    );

    tcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nonempty     (nonempty),
        .item         (rd_item),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .tcp_checksum (tcp_checksum),
        .length_error (length_error)
    );

endmodule
